FILE: hdl/delimited_frame_receiver_fifo_unit_defines.svh
// ----------------------------------------------------------------------------
// delimited frame receiver fifo unit assertion macros
// concurrent assertion wrappers, empty when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_RECEIVER_FIFO_UNIT_DEFINES_SVH
`define DELIMITED_FRAME_RECEIVER_FIFO_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DFR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define DFR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DFR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define DFR_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// shared codes and controller/datapath interface types of the frame receiver
// ----------------------------------------------------------------------------
package dfr_pkg;

   localparam logic [1:0] ACT_RECV  = 2'd0;
   localparam logic [1:0] ACT_POP   = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [2:0] STS_BYTE_TAKEN   = 3'd0;
   localparam logic [2:0] STS_FRAME_QUEUED = 3'd1;
   localparam logic [2:0] STS_FRAME_DROP   = 3'd2;
   localparam logic [2:0] STS_IGNORED      = 3'd3;
   localparam logic [2:0] STS_POPPED       = 3'd4;
   localparam logic [2:0] STS_EMPTY        = 3'd5;
   localparam logic [2:0] STS_CLEARED      = 3'd6;

   localparam logic [7:0] START_BYTE = 8'h03;
   localparam logic [7:0] END_BYTE   = 8'hF4;

   typedef enum logic [1:0] {
      ROUTE_NONE,
      ROUTE_RESULT,
      ROUTE_PUSH,
      ROUTE_POP
   } route_type;

   typedef struct packed {
      logic accept;
      logic idx_clear;
      logic idx_inc;
      logic push_write;
      logic pop_read;
      logic pop_emit;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      route_type route;
      logic      out_free;
      logic      idx_last;
   } stat_type;

endpackage

FILE: hdl/dfr_controller.sv
// ----------------------------------------------------------------------------
// dfr_controller
// sequencer for accept, frame copy sweep, pop readout and result loading
// ----------------------------------------------------------------------------
`include "delimited_frame_receiver_fifo_unit_defines.svh"

module dfr_controller import dfr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat_i,
   output cmd_type  cmd_o
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_RESULT = 5'b00010,
      ST_PUSH   = 5'b00100,
      ST_POP_RD = 5'b01000,
      ST_POP_EM = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd_o     = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd_o.accept    = req_valid;
            cmd_o.idx_clear = req_valid;
            if (req_valid) begin
               unique case (stat_i.route)
                  ROUTE_RESULT: state_in = ST_RESULT;
                  ROUTE_PUSH:   state_in = ST_PUSH;
                  ROUTE_POP:    state_in = ST_POP_RD;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_RESULT: begin
            if (stat_i.out_free) begin
               cmd_o.load_result = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_PUSH: begin
            cmd_o.push_write = 1'b1;
            if (stat_i.idx_last) begin
               state_in = ST_RESULT;
            end else begin
               cmd_o.idx_inc = 1'b1;
            end
         end
         ST_POP_RD: begin
            cmd_o.pop_read = 1'b1;
            state_in       = ST_POP_EM;
         end
         ST_POP_EM: begin
            if (stat_i.out_free) begin
               cmd_o.pop_emit = 1'b1;
               if (stat_i.idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd_o.idx_inc = 1'b1;
                  state_in      = ST_POP_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DFR_ASSERT_IMP(a_emit_after_read, clock, reset, state_ff == ST_POP_EM,
      $past(state_ff) == ST_POP_RD || $past(state_ff) == ST_POP_EM,
      "pop emit state entered without a memory read")
   `DFR_ASSERT_NXT(a_accept_leaves_idle, clock, reset,
      cmd_o.accept && stat_i.route != ROUTE_NONE, state_ff != ST_IDLE,
      "accepted beat with results did not leave idle")

endmodule

FILE: hdl/dfr_datapath.sv
// ----------------------------------------------------------------------------
// dfr_datapath
// frame register, frame memory, ring pointers and result register
// ----------------------------------------------------------------------------
`include "delimited_frame_receiver_fifo_unit_defines.svh"

module dfr_datapath import dfr_pkg::*; #(
   parameter int FRAME_BYTES = 9,
   parameter int FIFO_SLOTS  = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic [1:0] req_action,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_last,
   output logic [2:0] rsp_frame_count,
   output logic       rsp_fifo_full,
   input  cmd_type    cmd_i,
   output stat_type   stat_o
);

   localparam int PTR_W  = $clog2(FIFO_SLOTS);
   localparam int CNT_W  = PTR_W + 1;
   localparam int IDX_W  = $clog2(FRAME_BYTES);
   localparam int DEPTH  = FIFO_SLOTS * FRAME_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic             master_ff, master_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] slot_ff, slot_in;
   logic [2:0]       status_ff, status_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [FRAME_BYTES-1:0] nz_ff, nz_in;
   logic [7:0]             asm_ff [FRAME_BYTES];
   logic [7:0]             asm_in [FRAME_BYTES];
   logic [FRAME_BYTES-1:0] first_zero;

   logic [7:0]       mem [DEPTH];
   logic [7:0]       mem_rd_ff;
   logic [ADDR_W-1:0] addr;
   logic [7:0]       asm_rd;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;
   logic [2:0]       rsp_count_ff;
   logic             rsp_full_ff;

   logic [PTR_W-1:0] wp_next, rp_next;
   logic             full, empty;
   logic [CNT_W-1:0] held;
   logic [CNT_W+2:0] held_pad;
   route_type        route;
   logic [2:0]       route_status;

   assign wp_next = (wp_ff == PTR_W'(FIFO_SLOTS - 1)) ? '0 : wp_ff + PTR_W'(1);
   assign rp_next = (rp_ff == PTR_W'(FIFO_SLOTS - 1)) ? '0 : rp_ff + PTR_W'(1);
   assign full    = (wp_next == rp_ff);
   assign empty   = (wp_ff == rp_ff);

   always_comb begin
      if (wp_ff >= rp_ff) begin
         held = CNT_W'(wp_ff) - CNT_W'(rp_ff);
      end else begin
         held = CNT_W'(FIFO_SLOTS) - CNT_W'(rp_ff) + CNT_W'(wp_ff);
      end
   end
   assign held_pad = {3'b000, held};

   assign first_zero = ~nz_ff & (nz_ff + FRAME_BYTES'(1));

   always_comb begin
      route        = ROUTE_NONE;
      route_status = STS_BYTE_TAKEN;
      unique case (req_action)
         ACT_RECV: begin
            route = ROUTE_RESULT;
            priority if (master_ff) begin
               route_status = STS_IGNORED;
            end else if (req_rx_byte == END_BYTE) begin
               if (full) begin
                  route_status = STS_FRAME_DROP;
               end else begin
                  route        = ROUTE_PUSH;
                  route_status = STS_FRAME_QUEUED;
               end
            end else begin
               route_status = STS_BYTE_TAKEN;
            end
         end
         ACT_POP: begin
            if (empty) begin
               route        = ROUTE_RESULT;
               route_status = STS_EMPTY;
            end else begin
               route        = ROUTE_POP;
               route_status = STS_POPPED;
            end
         end
         ACT_CLEAR: begin
            route        = ROUTE_RESULT;
            route_status = STS_CLEARED;
         end
         default: route = ROUTE_NONE;
      endcase
   end

   always_comb begin
      master_in = csr_write_enable ? csr_write_data : master_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      slot_in   = slot_ff;
      status_in = status_ff;
      nz_in     = nz_ff;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         asm_in[i] = asm_ff[i];
      end
      if (cmd_i.accept) begin
         status_in = route_status;
         unique case (req_action)
            ACT_RECV: begin
               if (!master_ff) begin
                  priority if (req_rx_byte == START_BYTE) begin
                     nz_in     = FRAME_BYTES'(1);
                     asm_in[0] = START_BYTE;
                  end else if (req_rx_byte == END_BYTE) begin
                     nz_in[FRAME_BYTES-1]  = 1'b1;
                     asm_in[FRAME_BYTES-1] = END_BYTE;
                     if (!full) begin
                        slot_in = wp_ff;
                        wp_in   = wp_next;
                     end
                  end else begin
                     for (int i = 0; i < FRAME_BYTES; i++) begin
                        if (first_zero[i]) begin
                           asm_in[i] = req_rx_byte;
                           nz_in[i]  = (req_rx_byte != 8'h00);
                        end
                     end
                  end
               end
            end
            ACT_POP: begin
               if (!empty) begin
                  slot_in = rp_ff;
                  rp_in   = rp_next;
               end
            end
            ACT_CLEAR: begin
               wp_in = '0;
               rp_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      priority if (cmd_i.idx_clear) begin
         idx_in = '0;
      end else if (cmd_i.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   assign asm_rd = nz_ff[idx_ff] ? asm_ff[idx_ff] : 8'h00;
   assign addr   = ADDR_W'(slot_ff) * ADDR_W'(FRAME_BYTES) + ADDR_W'(idx_ff);

   always_ff @(posedge clock) begin
      if (cmd_i.push_write) begin
         mem[addr] <= asm_rd;
      end
      if (cmd_i.pop_read) begin
         mem_rd_ff <= mem[addr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd_i.load_result || cmd_i.pop_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= 1'b1;
         wp_ff        <= '0;
         rp_ff        <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         master_ff    <= master_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         asm_ff[i] <= asm_in[i];
      end
      if (cmd_i.load_result) begin
         rsp_status_ff <= status_ff;
         rsp_byte_ff   <= 8'h00;
         rsp_last_ff   <= 1'b1;
         rsp_count_ff  <= held_pad[2:0];
         rsp_full_ff   <= full;
      end else if (cmd_i.pop_emit) begin
         rsp_status_ff <= STS_POPPED;
         rsp_byte_ff   <= mem_rd_ff;
         rsp_last_ff   <= stat_o.idx_last;
         rsp_count_ff  <= held_pad[2:0];
         rsp_full_ff   <= full;
      end
   end

   assign stat_o.route    = route;
   assign stat_o.out_free = !rsp_valid_ff || rsp_ready;
   assign stat_o.idx_last = (idx_ff == IDX_W'(FRAME_BYTES - 1));

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_frame_byte  = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_frame_count = rsp_count_ff;
   assign rsp_fifo_full   = rsp_full_ff;

   `DFR_ASSERT_NXT(a_push_not_empty, clock, reset,
      cmd_i.accept && route == ROUTE_PUSH, wp_ff != rp_ff,
      "frame push left the fifo empty")
   `DFR_ASSERT_NXT(a_clear_pointers, clock, reset,
      cmd_i.accept && req_action == ACT_CLEAR, wp_ff == '0 && rp_ff == '0,
      "clear did not zero the pointers")
   `DFR_ASSERT_IMP(a_rsp_from_load, clock, reset, $rose(rsp_valid_ff),
      $past(cmd_i.load_result || cmd_i.pop_emit),
      "result register became valid without a load")

endmodule

FILE: hdl/delimited_frame_receiver_fifo_unit.sv
// ----------------------------------------------------------------------------
// delimited_frame_receiver_fifo_unit
// assembles delimited frames from received bytes and queues them in a ring
// fifo; a pop streams one stored frame out byte by byte
// ----------------------------------------------------------------------------
// result beats: after accept, loaded once the result register is free
// push: frame register copied to its slot byte by byte, then a result beat
// pop: each frame byte is read from memory, then loaded into the output
// one request in flight; next request taken in the cycle after its last load
// reset: pointers zero, frame register empty, master mode set, memory untouched
module delimited_frame_receiver_fifo_unit import dfr_pkg::*; #(
   parameter int FRAME_BYTES = 9,
   parameter int FIFO_SLOTS  = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_last,
   output logic [2:0] rsp_frame_count,
   output logic       rsp_fifo_full
);

   cmd_type  cmd;
   stat_type stat;

   dfr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   dfr_datapath #(
      .FRAME_BYTES (FRAME_BYTES),
      .FIFO_SLOTS  (FIFO_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_action       (req_action),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_last         (rsp_last),
      .rsp_frame_count  (rsp_frame_count),
      .rsp_fifo_full    (rsp_fifo_full),
      .cmd_i            (cmd),
      .stat_o           (stat)
   );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame receiver fifo testbench
// drives receive, pop, clear and unused request beats into the frame receiver
// under random idling and long result stalls; a local frame assembler and
// ring fifo predict every result beat, which is checked in order
// ----------------------------------------------------------------------------
module testbench import dfr_pkg::*; ();

   localparam int FRAME_LEN = 9;
   localparam int SLOTS = 8;
   localparam int LIMIT_CYCLES = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] frame_byte;
      logic       last;
      logic [2:0] frame_count;
      logic       fifo_full;
   } result_beat_type;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic       csr_write_data;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_action;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_status;
   logic [7:0] rsp_frame_byte;
   logic       rsp_last;
   logic [2:0] rsp_frame_count;
   logic       rsp_fifo_full;

   // frame receiver prediction state
   logic       mode_master;
   logic [7:0] asm_frame [FRAME_LEN];
   logic [7:0] frame_store [SLOTS][FRAME_LEN];
   int         wr_ptr;
   int         rd_ptr;
   result_beat_type expected_beats [$];

   int error_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int beats_checked = 0;
   int frames_queued = 0;
   int frames_dropped = 0;
   int frames_popped = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles = 0;

   delimited_frame_receiver_fifo_unit #(
      .FRAME_BYTES(FRAME_LEN),
      .FIFO_SLOTS (SLOTS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_last        (rsp_last),
      .rsp_frame_count (rsp_frame_count),
      .rsp_fifo_full   (rsp_fifo_full)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int next_slot(input int p);
      return (p + 1 >= SLOTS) ? 0 : p + 1;
   endfunction

   function automatic void queue_beat(input logic [2:0] sts, input logic [7:0] fbyte,
                                      input logic lst);
      result_beat_type beat;
      beat.status      = sts;
      beat.frame_byte  = fbyte;
      beat.last        = lst;
      beat.frame_count = 3'((wr_ptr + SLOTS - rd_ptr) % SLOTS);
      beat.fifo_full   = (next_slot(wr_ptr) == rd_ptr);
      expected_beats.push_back(beat);
   endfunction

   function automatic void predict_frame_step(input logic [1:0] action,
                                              input logic [7:0] rx);
      logic [2:0] sts;
      int         src;
      int         i;
      case (action)
         ACT_RECV: begin
            sts = STS_BYTE_TAKEN;
            if (mode_master) begin
               sts = STS_IGNORED;
            end else if (rx == START_BYTE) begin
               for (i = 0; i < FRAME_LEN; i++) asm_frame[i] = 8'h00;
               asm_frame[0] = rx;
            end else if (rx == END_BYTE) begin
               asm_frame[FRAME_LEN-1] = rx;
               if (next_slot(wr_ptr) == rd_ptr) begin
                  sts = STS_FRAME_DROP;
                  frames_dropped++;
               end else begin
                  for (i = 0; i < FRAME_LEN; i++) frame_store[wr_ptr][i] = asm_frame[i];
                  wr_ptr = next_slot(wr_ptr);
                  sts = STS_FRAME_QUEUED;
                  frames_queued++;
               end
            end else begin
               for (i = 0; i < FRAME_LEN; i++) begin
                  if (asm_frame[i] == 8'h00) begin
                     asm_frame[i] = rx;
                     break;
                  end
               end
            end
            queue_beat(sts, 8'h00, 1'b1);
         end
         ACT_POP: begin
            if (wr_ptr == rd_ptr) begin
               queue_beat(STS_EMPTY, 8'h00, 1'b1);
            end else begin
               src = rd_ptr;
               rd_ptr = next_slot(rd_ptr);
               for (i = 0; i < FRAME_LEN; i++)
                  queue_beat(STS_POPPED, frame_store[src][i], i == FRAME_LEN - 1);
            end
         end
         ACT_CLEAR: begin
            wr_ptr = 0;
            rd_ptr = 0;
            queue_beat(STS_CLEARED, 8'h00, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic flag_error(input string msg);
      $display("[%0t] ERROR: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      result_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            flag_error($sformatf("result beat with nothing pending, status %0d", rsp_status));
         end else begin
            want = expected_beats.pop_front();
            beats_checked++;
            if (want.status == STS_POPPED && want.last) frames_popped++;
            if (rsp_status !== want.status)
               flag_error($sformatf("status %0d, wanted %0d", rsp_status, want.status));
            if (rsp_frame_byte !== want.frame_byte)
               flag_error($sformatf("frame byte %02h, wanted %02h",
                                    rsp_frame_byte, want.frame_byte));
            if (rsp_last !== want.last)
               flag_error($sformatf("last %0b, wanted %0b", rsp_last, want.last));
            if (rsp_frame_count !== want.frame_count)
               flag_error($sformatf("frame count %0d, wanted %0d",
                                    rsp_frame_count, want.frame_count));
            if (rsp_fifo_full !== want.fifo_full)
               flag_error($sformatf("fifo full %0b, wanted %0b",
                                    rsp_fifo_full, want.fifo_full));
         end
      end
   end

   // result side: long hold-off first, otherwise random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d beats pending",
                  cycle_count, expected_beats.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_beat(input logic [1:0] action, input logic [7:0] rx);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= action;
      req_rx_byte <= rx;
      do @(posedge clock); while (!req_ready);
      predict_frame_step(action, rx);
      if (action != ACT_UNUSED) items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   task automatic set_master_mode(input logic m);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      mode_master = m;
   endtask

   function automatic logic [7:0] random_data();
      return ($urandom_range(15) == 0) ? 8'h00 : 8'($urandom_range(255));
   endfunction

   // start byte, data bytes, end byte; now and then a delimiter goes missing
   task automatic send_frame();
      int n;
      int k;
      n = $urandom_range(10);
      if ($urandom_range(9) != 0) send_beat(ACT_RECV, START_BYTE);
      for (k = 0; k < n; k++) send_beat(ACT_RECV, random_data());
      if ($urandom_range(9) != 0) send_beat(ACT_RECV, END_BYTE);
   endtask

   task automatic send_random_items(input int n);
      int start;
      int roll;
      start = items_sent;
      while (items_sent - start < n) begin
         roll = $urandom_range(99);
         if (roll < 50) send_frame();
         else if (roll < 80) send_beat(ACT_POP, 8'($urandom_range(255)));
         else if (roll < 86) send_beat(ACT_CLEAR, 8'($urandom_range(255)));
         else if (roll < 91) send_beat(ACT_UNUSED, 8'($urandom_range(255)));
         else send_beat(ACT_RECV, 8'($urandom_range(255)));
      end
   endtask

   task automatic test_master_ignores();
      send_beat(ACT_RECV, START_BYTE);
      send_beat(ACT_POP, 8'hFF);
      send_beat(ACT_CLEAR, 8'h00);
      send_beat(ACT_UNUSED, 8'hFF);
   endtask

   task automatic test_frame_assembly();
      logic [7:0] bytes [12] = '{8'h03, 8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01,
                                 8'h80, 8'h7F, 8'h10, 8'h20, 8'h42, 8'hF4};
      int k;
      set_master_mode(1'b0);
      foreach (bytes[k]) send_beat(ACT_RECV, bytes[k]);
      // same frame again until the fifo is full, then one more is dropped
      for (k = 0; k < SLOTS - 1; k++) send_beat(ACT_RECV, END_BYTE);
      send_beat(ACT_POP, 8'h00);
      send_beat(ACT_CLEAR, 8'hFF);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
      drain_results();
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      send_random_items(n);
   endtask

   task automatic test_backpressure();
      drain_results();
      send_idle_pct = 0;
      @(posedge clock);
      hold_cycles = HOLD_CYCLES;
      send_random_items(30);
      drain_results();
      send_random_items(10);
   endtask

   task automatic test_master_traffic();
      set_master_mode(1'b1);
      send_random_items(20);
      set_master_mode(1'b0);
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_valid = 1'b0;
      req_action = ACT_RECV;
      req_rx_byte = 8'h00;
      rsp_ready = 1'b0;
      mode_master = 1'b1;
      for (int i = 0; i < FRAME_LEN; i++) asm_frame[i] = 8'h00;
      wr_ptr = 0;
      rd_ptr = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_master_ignores();
      test_frame_assembly();
      test_random_traffic(22, 78, 90);
      test_backpressure();
      test_master_traffic();
      test_random_traffic(78, 22, 70);
      test_random_traffic(0, 0, 70);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d request beats and %0d result beats in both modes",
               items_sent, beats_checked);
      $display("frames queued %0d, dropped on full %0d, popped %0d",
               frames_queued, frames_dropped, frames_popped);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
